FILE: hw/rtl/bce_pkg.sv
// Shared types, widths, and the log table for the binary cross-entropy pipeline.
package bce_pkg;

   // Fraction bits of probability, label, and loss; works from 8 to 24.
   localparam int FRAC_BITS = 16;

   localparam int IN_W    = FRAC_BITS + 1;
   localparam int OUT_W   = FRAC_BITS + 7;
   localparam int KW      = $clog2(IN_W);
   localparam int MANT_W  = 24;
   localparam int SHIFT_W = 5;
   localparam int IDX_W   = 4;
   localparam int REM_W   = MANT_W - IDX_W;
   localparam int TAB_W   = 16;
   localparam int TAB_IW  = IDX_W + 1;
   localparam int DIFF_W  = 12;
   localparam int PROD_W  = 32;
   localparam int LNM_W   = 17;
   localparam int WHOLE_W = 21;
   localparam int NL_W    = 23;
   localparam int MUL_W   = IN_W + NL_W;
   localparam int SUM_W   = MUL_W + 1;
   localparam int NUM_STAGES = 5;

   localparam logic [IN_W-1:0]    ONE_FX   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [NL_W-1:0]    CLIP_Q16 = NL_W'(100) << 16;
   localparam logic [TAB_W-1:0]   LN_TWO   = 16'd45426;
   localparam logic [OUT_W-1:0]   LOSS_MAX = OUT_W'(100) << FRAC_BITS;

   typedef struct packed {
      logic [IN_W-1:0] pred_prob;
      logic [IN_W-1:0] label_value;
      logic            is_last;
   } req_data_type;

   typedef struct packed {
      logic [OUT_W-1:0] loss_value;
      logic             last_out;
   } rsp_data_type;

   // One load enable per pipeline stage.
   typedef struct packed {
      logic norm;
      logic interp;
      logic finish;
      logic scale;
      logic total;
   } pipe_load_type;

   // ln(1 + i/16) in Q16.
   function automatic logic [TAB_W-1:0] ln_tab(input logic [TAB_IW-1:0] idx);
      logic [TAB_W-1:0] val;
      unique case (idx)
         5'd0:    val = 16'd0;
         5'd1:    val = 16'd3973;
         5'd2:    val = 16'd7719;
         5'd3:    val = 16'd11262;
         5'd4:    val = 16'd14624;
         5'd5:    val = 16'd17821;
         5'd6:    val = 16'd20870;
         5'd7:    val = 16'd23783;
         5'd8:    val = 16'd26573;
         5'd9:    val = 16'd29248;
         5'd10:   val = 16'd31818;
         5'd11:   val = 16'd34292;
         5'd12:   val = 16'd36675;
         5'd13:   val = 16'd38975;
         5'd14:   val = 16'd41196;
         5'd15:   val = 16'd43345;
         5'd16:   val = 16'd45426;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage

FILE: hw/rtl/bce_log.sv
// Three-stage clipped negative natural log of a fixed-point probability.
module bce_log (
   input  logic                          clock,
   input  bce_pkg::pipe_load_type        load,
   input  logic [bce_pkg::IN_W-1:0]      x,
   output logic [bce_pkg::NL_W-1:0]      nl
);

   // Stage 1: normalize.
   logic [bce_pkg::KW-1:0]      k_in, k_ff;
   logic [bce_pkg::MANT_W-1:0]  f_in, f_ff;
   logic                        zero_in, zero1_ff;
   logic [bce_pkg::SHIFT_W-1:0] shift_amt;
   logic [bce_pkg::MANT_W:0]    x_shifted;

   always_comb begin
      k_in = '0;
      for (int i = 0; i < bce_pkg::IN_W; i++) begin
         if (x[i]) begin
            k_in = bce_pkg::KW'(i);
         end
      end
   end

   // The leading one lands on the bit just above the mantissa and drops off.
   assign shift_amt = bce_pkg::SHIFT_W'(bce_pkg::MANT_W) - bce_pkg::SHIFT_W'(k_in);
   assign x_shifted = (bce_pkg::MANT_W+1)'(x) << shift_amt;
   assign f_in      = x_shifted[bce_pkg::MANT_W-1:0];
   assign zero_in   = (x == '0);

   always_ff @(posedge clock) begin
      if (load.norm) begin
         k_ff     <= k_in;
         f_ff     <= f_in;
         zero1_ff <= zero_in;
      end
   end

   // Stage 2: table lookup, slope times remainder, whole-octave term.
   logic [bce_pkg::IDX_W-1:0]   idx;
   logic [bce_pkg::REM_W-1:0]   rem;
   logic [bce_pkg::TAB_W-1:0]   t_lo_in, t_lo_ff, t_hi;
   logic [bce_pkg::DIFF_W-1:0]  diff;
   logic [bce_pkg::PROD_W-1:0]  prod_in, prod_ff;
   logic [bce_pkg::WHOLE_W-1:0] whole_in, whole_ff;
   logic                        zero2_ff;

   assign idx      = f_ff[bce_pkg::MANT_W-1 -: bce_pkg::IDX_W];
   assign rem      = f_ff[bce_pkg::REM_W-1:0];
   assign t_lo_in  = bce_pkg::ln_tab({1'b0, idx});
   assign t_hi     = bce_pkg::ln_tab({1'b0, idx} + bce_pkg::TAB_IW'(1));
   assign diff     = bce_pkg::DIFF_W'(t_hi - t_lo_in);
   assign prod_in  = bce_pkg::PROD_W'(diff) * bce_pkg::PROD_W'(rem);
   assign whole_in = bce_pkg::WHOLE_W'(bce_pkg::KW'(bce_pkg::FRAC_BITS) - k_ff)
                     * bce_pkg::WHOLE_W'(bce_pkg::LN_TWO);

   always_ff @(posedge clock) begin
      if (load.interp) begin
         t_lo_ff  <= t_lo_in;
         prod_ff  <= prod_in;
         whole_ff <= whole_in;
         zero2_ff <= zero1_ff;
      end
   end

   // Stage 3: round the interpolation, subtract, clip.
   logic [bce_pkg::PROD_W:0]    prod_rnd;
   logic [bce_pkg::LNM_W-1:0]   lnm;
   logic [bce_pkg::WHOLE_W-1:0] lnm_ext, delta;
   logic [bce_pkg::NL_W-1:0]    delta_ext, nl_in, nl_ff;

   assign prod_rnd  = (bce_pkg::PROD_W+1)'(prod_ff) + ((bce_pkg::PROD_W+1)'(1) << (bce_pkg::REM_W-1));
   assign lnm       = bce_pkg::LNM_W'(t_lo_ff)
                      + bce_pkg::LNM_W'(prod_rnd[bce_pkg::PROD_W:bce_pkg::REM_W]);
   assign lnm_ext   = bce_pkg::WHOLE_W'(lnm);
   assign delta     = whole_ff - lnm_ext;
   assign delta_ext = bce_pkg::NL_W'(delta);

   always_comb begin
      priority if (zero2_ff) begin
         nl_in = bce_pkg::CLIP_Q16;
      end else if (whole_ff <= lnm_ext) begin
         nl_in = '0;
      end else if (delta_ext > bce_pkg::CLIP_Q16) begin
         nl_in = bce_pkg::CLIP_Q16;
      end else begin
         nl_in = delta_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (load.finish) begin
         nl_ff <= nl_in;
      end
   end

   assign nl = nl_ff;

endmodule

FILE: hw/rtl/bce_mix.sv
// Two-stage label weighting of both log terms, rounding, and saturation.
module bce_mix (
   input  logic                         clock,
   input  bce_pkg::pipe_load_type       load,
   input  logic [bce_pkg::IN_W-1:0]     label,
   input  logic [bce_pkg::NL_W-1:0]     nl_pos,
   input  logic [bce_pkg::NL_W-1:0]     nl_neg,
   output logic [bce_pkg::OUT_W-1:0]    loss
);

   localparam int SHR_W = bce_pkg::SUM_W - 16;

   logic [bce_pkg::IN_W-1:0]  label_inv;
   logic [bce_pkg::MUL_W-1:0] prod_pos_in, prod_pos_ff, prod_neg_in, prod_neg_ff;

   assign label_inv   = bce_pkg::ONE_FX - label;
   assign prod_pos_in = bce_pkg::MUL_W'(label) * bce_pkg::MUL_W'(nl_pos);
   assign prod_neg_in = bce_pkg::MUL_W'(label_inv) * bce_pkg::MUL_W'(nl_neg);

   always_ff @(posedge clock) begin
      if (load.scale) begin
         prod_pos_ff <= prod_pos_in;
         prod_neg_ff <= prod_neg_in;
      end
   end

   logic [bce_pkg::SUM_W-1:0] sum_rnd;
   logic [SHR_W-1:0]          sum_q;
   logic [bce_pkg::OUT_W-1:0] loss_in, loss_ff;

   // The log terms are Q16, so the sum drops 16 bits with round-half-up.
   assign sum_rnd = bce_pkg::SUM_W'(prod_pos_ff) + bce_pkg::SUM_W'(prod_neg_ff)
                    + (bce_pkg::SUM_W'(1) << 15);
   assign sum_q   = sum_rnd[bce_pkg::SUM_W-1:16];
   assign loss_in = (sum_q > SHR_W'(bce_pkg::LOSS_MAX)) ? bce_pkg::LOSS_MAX
                                                         : bce_pkg::OUT_W'(sum_q);

   always_ff @(posedge clock) begin
      if (load.total) begin
         loss_ff <= loss_in;
      end
   end

   assign loss = loss_ff;

endmodule

FILE: hw/rtl/binary_cross_entropy_loss.sv
// Throughput: one beat per cycle while rsp_stall is low.
// Each stage moves on when it is empty or the next one moves.
// The clamp and leading-one shift, the table interpolation multiply, the log subtract and
// clip, the label multiplies, and the final sum and saturation each get a stage of their
// own, which sets the five-stage depth.
// Reset clears the stage valid bits only; the block is ready in the cycle after reset.
module binary_cross_entropy_loss (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bce_pkg::req_data_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bce_pkg::rsp_data_type  rsp_data
);

   localparam int NS = bce_pkg::NUM_STAGES;

   logic [NS-1:0] valid_ff, valid_in, adv;
   bce_pkg::pipe_load_type load;

   always_comb begin
      adv[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int s = NS - 2; s >= 0; s--) begin
         adv[s] = !valid_ff[s] || adv[s+1];
      end
   end

   assign valid_in = {valid_ff[NS-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (adv[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   assign load.norm   = adv[0];
   assign load.interp = adv[1];
   assign load.finish = adv[2];
   assign load.scale  = adv[3];
   assign load.total  = adv[4];

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[NS-1];

   // Inputs above one saturate to one.
   logic [bce_pkg::IN_W-1:0] prob_sat, prob_inv, label_sat;

   assign prob_sat  = (req_data.pred_prob > bce_pkg::ONE_FX) ? bce_pkg::ONE_FX
                                                             : req_data.pred_prob;
   assign label_sat = (req_data.label_value > bce_pkg::ONE_FX) ? bce_pkg::ONE_FX
                                                               : req_data.label_value;
   assign prob_inv  = bce_pkg::ONE_FX - prob_sat;

   logic [bce_pkg::NL_W-1:0] nl_pos, nl_neg;

   bce_log u_log_pos (
      .clock (clock),
      .load  (load),
      .x     (prob_sat),
      .nl    (nl_pos)
   );

   bce_log u_log_neg (
      .clock (clock),
      .load  (load),
      .x     (prob_inv),
      .nl    (nl_neg)
   );

   // The label rides alongside the log stages; the last flag rides alongside every stage.
   logic [bce_pkg::IN_W-1:0] label1_ff, label2_ff, label3_ff;
   logic [NS-1:0]            last_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         label1_ff  <= label_sat;
         last_ff[0] <= req_data.is_last;
      end
      if (adv[1]) begin
         label2_ff  <= label1_ff;
         last_ff[1] <= last_ff[0];
      end
      if (adv[2]) begin
         label3_ff  <= label2_ff;
         last_ff[2] <= last_ff[1];
      end
      if (adv[3]) begin
         last_ff[3] <= last_ff[2];
      end
      if (adv[4]) begin
         last_ff[4] <= last_ff[3];
      end
   end

   logic [bce_pkg::OUT_W-1:0] loss;

   bce_mix u_mix (
      .clock  (clock),
      .load   (load),
      .label  (label3_ff),
      .nl_pos (nl_pos),
      .nl_neg (nl_neg),
      .loss   (loss)
   );

   assign rsp_data.loss_value = loss;
   assign rsp_data.last_out   = last_ff[NS-1];

`ifndef SYNTHESIS
   // An open output lets every stage move, so the input is never held.
   assert property (@(posedge clock) disable iff (reset) !rsp_stall |-> !req_stall)
      else $error("input stalled while output is open");

   // An empty first stage always takes a beat.
   assert property (@(posedge clock) disable iff (reset) !valid_ff[0] |-> !req_stall)
      else $error("input stalled with empty first stage");

   // A full pipeline behind a stalled output must hold the input.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_stall && (&valid_ff)) |-> req_stall)
      else $error("full pipeline accepted a beat");

   // The loss never exceeds the clip value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.loss_value <= bce_pkg::LOSS_MAX))
      else $error("loss above clip value");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the binary cross-entropy loss pipeline.
module tb_top;
   import bce_pkg::*;

   localparam int NUM_DIRECTED = 18;
   localparam int LONG_HOLD    = 80;
   localparam logic [IN_W-1:0] P_HALF = ONE_FX >> 1;
   localparam logic [IN_W-1:0] P_ALL  = '1;
   localparam logic [63:0] CLIP_LOG = 64'd100 << 16;
   localparam logic [63:0] LOSS_CAP = 64'd100 << FRAC_BITS;

   // ln(1 + i/16) in Q16, the same points the hardware interpolates between.
   localparam logic [15:0] LN_POINTS [17] = '{
      16'd0, 16'd3973, 16'd7719, 16'd11262, 16'd14624, 16'd17821, 16'd20870,
      16'd23783, 16'd26573, 16'd29248, 16'd31818, 16'd34292, 16'd36675,
      16'd38975, 16'd41196, 16'd43345, 16'd45426
   };

   typedef struct {
      logic [IN_W-1:0]  prob;
      logic [IN_W-1:0]  label;
      logic             last;
      bit               known;
      logic [OUT_W-1:0] loss;
   } bce_vector_type;

   // Rows marked known carry a loss that follows directly from the clipping rules.
   bce_vector_type directed_rows [NUM_DIRECTED] = '{
      '{'0,          ONE_FX,     1'b1, 1'b1, LOSS_MAX},
      '{'0,          '0,         1'b0, 1'b1, '0},
      '{ONE_FX,      ONE_FX,     1'b0, 1'b1, '0},
      '{ONE_FX,      '0,         1'b1, 1'b1, LOSS_MAX},
      '{P_ALL,       P_ALL,      1'b0, 1'b1, '0},
      '{P_ALL,       '0,         1'b0, 1'b1, LOSS_MAX},
      '{'0,          P_ALL,      1'b1, 1'b1, LOSS_MAX},
      '{ONE_FX + 1,  P_HALF,     1'b0, 1'b0, '0},
      '{'0,          P_HALF,     1'b1, 1'b0, '0},
      '{P_HALF,      ONE_FX,     1'b0, 1'b0, '0},
      '{P_HALF,      '0,         1'b1, 1'b0, '0},
      '{P_HALF,      P_HALF,     1'b0, 1'b0, '0},
      '{IN_W'(1),    ONE_FX,     1'b0, 1'b0, '0},
      '{IN_W'(1),    '0,         1'b1, 1'b0, '0},
      '{ONE_FX - 1,  '0,         1'b0, 1'b0, '0},
      '{ONE_FX - 1,  ONE_FX,     1'b1, 1'b0, '0},
      '{IN_W'('h0AAAA), IN_W'('h15555), 1'b0, 1'b0, '0},
      '{IN_W'('h05555), IN_W'('h0AAAA), 1'b1, 1'b0, '0}
   };

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_data_type rsp_data;

   rsp_data_type pending_loss_q [$];
   rsp_data_type oldest_loss;
   int           errors = 0;
   bit           tx_quiet = 1'b0;
   bit           rx_quiet = 1'b0;
   bit           hold_rsp_req = 1'b0;

   binary_cross_entropy_loss dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // -ln(x / 2^FRAC_BITS) in Q16, clipped at 100; log of zero is the clip value.
   function automatic logic [63:0] minus_log_q16(input logic [63:0] x);
      int          msb;
      int          idx;
      logic [63:0] frac, mant, rem, interp, whole;
      if (x == 0) return CLIP_LOG;
      msb = 0;
      for (int b = 0; b < 64; b++) begin
         if (x[b]) msb = b;
      end
      if (msb > 24) msb = 24;
      frac = x - (64'd1 << msb);
      mant = (frac << (24 - msb)) & 64'hFF_FFFF;
      idx = int'(mant >> 20) & 15;
      rem = mant & 64'hF_FFFF;
      interp = 64'(LN_POINTS[idx]) +
               (((64'(LN_POINTS[idx + 1]) - 64'(LN_POINTS[idx])) * rem + (64'd1 << 19)) >> 20);
      whole = (msb < FRAC_BITS) ? 64'(FRAC_BITS - msb) * 64'(LN_POINTS[16]) : 64'd0;
      if (whole <= interp) return 64'd0;
      whole = whole - interp;
      return (whole > CLIP_LOG) ? CLIP_LOG : whole;
   endfunction

   function automatic rsp_data_type bce_loss_of(input req_data_type d);
      logic [63:0]  p, y, a, b, sum, loss;
      rsp_data_type r;
      p = 64'(d.pred_prob);
      y = 64'(d.label_value);
      if (p > 64'(ONE_FX)) p = 64'(ONE_FX);
      if (y > 64'(ONE_FX)) y = 64'(ONE_FX);
      a = minus_log_q16(p);
      b = minus_log_q16(64'(ONE_FX) - p);
      sum = y * a + (64'(ONE_FX) - y) * b;
      loss = (sum + (64'd1 << 15)) >> 16;
      if (loss > LOSS_CAP) loss = LOSS_CAP;
      r.loss_value = loss[OUT_W-1:0];
      r.last_out = d.is_last;
      return r;
   endfunction

   function automatic logic [IN_W-1:0] draw_prob();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ONE_FX;
         2: return IN_W'($urandom());
         3: return IN_W'($urandom_range(1, 255));
         4: return ONE_FX - IN_W'($urandom_range(1, 255));
         default: return IN_W'($urandom_range(0, ONE_FX));
      endcase
   endfunction

   function automatic logic [IN_W-1:0] draw_label();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ONE_FX;
         2: return IN_W'($urandom());
         default: return IN_W'($urandom_range(0, ONE_FX));
      endcase
   endfunction

   // Called at a rising edge; returns at the edge where the beat was taken.
   task automatic send_sample(input req_data_type d, input rsp_data_type want);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_loss_q.push_back(want);
   endtask

   task automatic send_random(input int count);
      req_data_type d;
      for (int i = 0; i < count; i++) begin
         d.pred_prob = draw_prob();
         d.label_value = draw_label();
         d.is_last = 1'($urandom_range(0, 1));
         send_sample(d, bce_loss_of(d));
      end
   endtask

   initial begin : stimulus
      req_data_type d;
      rsp_data_type want;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         d.pred_prob = directed_rows[i].prob;
         d.label_value = directed_rows[i].label;
         d.is_last = directed_rows[i].last;
         if (directed_rows[i].known) begin
            want.loss_value = directed_rows[i].loss;
            want.last_out = directed_rows[i].last;
         end else begin
            want = bce_loss_of(d);
         end
         send_sample(d, want);
      end

      send_random(300);

      // Keep offering beats back to back while the response side holds off.
      hold_rsp_req = 1'b1;
      tx_quiet = 1'b1;
      send_random(40);
      tx_quiet = 1'b0;

      // Drop valid so the last beat is not taken a second time while draining.
      req_valid <= 1'b0;
      while (pending_loss_q.size() != 0) @(posedge clock);

      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      send_random(200);
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;

      send_random(400);
      req_valid <= 1'b0;

      while (pending_loss_q.size() != 0) @(posedge clock);
      repeat (NUM_STAGES * 4) @(posedge clock);
      if (errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   initial begin : response_side
      int n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         n = 0;
         if (hold_rsp_req) begin
            n = LONG_HOLD;
            hold_rsp_req = 1'b0;
         end else if (rsp_valid && !rsp_stall && !rx_quiet) begin
            n = $urandom_range(0, 11);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_loss_q.size() == 0) begin
            $display("%0t: loss beat with nothing pending: %p", $time, rsp_data);
            errors++;
         end else begin
            oldest_loss = pending_loss_q.pop_front();
            if (rsp_data.loss_value !== oldest_loss.loss_value) begin
               $display("%0t: loss_value expected %0d, got %0d", $time,
                        oldest_loss.loss_value, rsp_data.loss_value);
               errors++;
            end
            if (rsp_data.last_out !== oldest_loss.last_out) begin
               $display("%0t: last_out expected %0b, got %0b", $time,
                        oldest_loss.last_out, rsp_data.last_out);
               errors++;
            end
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/bce_pkg.sv
hw/rtl/bce_log.sv
hw/rtl/bce_mix.sv
hw/rtl/binary_cross_entropy_loss.sv
tb/tb_top.sv
